[src/rbsi_pkg.sv]
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab intersect unit
// Fixed-point widths, saturation limits and pipeline record types.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int unsigned QW       = 32;   // Q16.16 word
  localparam int unsigned EPSW     = 16;   // parallel threshold width
  localparam int unsigned DISTW    = 31;   // result distance width
  localparam int unsigned AXES     = 3;
  localparam int unsigned LANES    = 6;    // lo x/y/z, hi x/y/z
  localparam int unsigned DIVSTEPS = 32;   // one quotient bit per stage

  localparam logic [EPSW-1:0] EPS_RESET = 16'd1;
  localparam logic signed [QW-1:0] T_MIN_SAT = 32'sh8000_0000;
  localparam logic signed [QW-1:0] T_MAX_SAT = 32'sh7FFF_FFFF;

  // one slab-distance division in flight
  typedef struct packed {
    logic [QW-1:0] rem;    // partial remainder, below dmag when ovf is clear
    logic [QW-1:0] q;      // numerator bits still to come, quotient bits shift in
    logic [QW-1:0] dmag;   // divisor magnitude
    logic          neg;    // quotient sign
    logic          ovf;    // magnitude already at or above 2^32
  } div_t;

  // per-axis parallel information that rides along with the divisions
  typedef struct packed {
    logic [AXES-1:0] par;    // axis treated as parallel
    logic [AXES-1:0] pmiss;  // origin outside the slab on this axis
  } side_t;

endpackage

[src/rbsi_if.sv]
// ----------------------------------------------------------------------------
// rbsi_if: stream interfaces of the ray/box slab intersect unit
// Ray/box input channel, result channel and threshold write channel.
// ----------------------------------------------------------------------------
interface rbsi_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] box_lo_x;
  logic signed [31:0] box_lo_y;
  logic signed [31:0] box_lo_z;
  logic signed [31:0] box_hi_x;
  logic signed [31:0] box_hi_y;
  logic signed [31:0] box_hi_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                output ready);
endinterface

interface rbsi_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

interface rbsi_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] parallel_epsilon;

  modport source (output valid, parallel_epsilon, input ready);
  modport sink (input valid, parallel_epsilon, output ready);
endinterface

[src/ray_box_slab_intersect_unit.sv]
// Pipeline: entry register, 32 divider stages, order stage, reduce stage,
// output register.
// Throughput: one ray/box pair per cycle unless the output stalls; the six
// slab divisions are restoring dividers pipelined one quotient bit per stage.
// Reset: synchronous rst clears all valid bits and sets parallel_epsilon to 1.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit: ray versus axis-aligned box, slab method
// Signed Q16.16 ray and box in, hit flag and saturated entry distance out.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit
  import rbsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rbsi_in_if.sink     ray_in,
  rbsi_out_if.source  hit_out,
  rbsi_cfg_if.sink    cfg
);

  // threshold reg, always ready; writes must arrive while idle (unchecked)
  logic [EPSW-1:0] eps;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg.valid) begin
      eps <= cfg.parallel_epsilon;
    end
  end

  // Whole pipeline moves as one: it advances whenever the output register is
  // free or being drained, so a stall freezes every stage together.
  logic adv;
  logic out_vld;
  logic out_hit;
  logic [DISTW-1:0] out_dist;

  assign adv          = !out_vld || hit_out.ready;
  assign ray_in.ready = adv;

  // ------------------------------------------------------------------
  // Entry: differences, magnitudes, signs and parallel tests
  // ------------------------------------------------------------------
  logic signed [QW-1:0] org [AXES];
  logic signed [QW-1:0] dir [AXES];
  logic signed [QW-1:0] crn [LANES];
  div_t  div_in [LANES];
  side_t side_in;

  assign org[0] = ray_in.origin_x;
  assign org[1] = ray_in.origin_y;
  assign org[2] = ray_in.origin_z;
  assign dir[0] = ray_in.dir_x;
  assign dir[1] = ray_in.dir_y;
  assign dir[2] = ray_in.dir_z;
  assign crn[0] = ray_in.box_lo_x;
  assign crn[1] = ray_in.box_lo_y;
  assign crn[2] = ray_in.box_lo_z;
  assign crn[3] = ray_in.box_hi_x;
  assign crn[4] = ray_in.box_hi_y;
  assign crn[5] = ray_in.box_hi_z;

  always_comb begin
    logic signed [QW:0] diff;
    logic [QW-1:0]      dmag;
    logic [QW-1:0]      nmag;
    for (int a = 0; a < AXES; a++) begin
      dmag = dir[a][QW-1] ? (~dir[a] + 32'd1) : dir[a];
      side_in.par[a]   = (dir[a] == '0) || (dmag < {16'd0, eps});
      side_in.pmiss[a] = (org[a] < crn[a]) || (org[a] > crn[a+AXES]);
    end
    for (int l = 0; l < LANES; l++) begin
      diff = {crn[l][QW-1], crn[l]} - {org[l % AXES][QW-1], org[l % AXES]};
      dmag = dir[l % AXES][QW-1] ? (~dir[l % AXES] + 32'd1) : dir[l % AXES];
      // |corner - origin| is below 2^32, so 32 bits hold it
      nmag = diff[QW] ? QW'(~diff + 33'd1) : diff[QW-1:0];
      // numerator = nmag * 2^16; top 16 bits seed the remainder
      div_in[l].rem  = {16'd0, nmag[31:16]};
      div_in[l].q    = {nmag[15:0], 16'd0};
      div_in[l].dmag = dmag;
      div_in[l].neg  = diff[QW] ^ dir[l % AXES][QW-1];
      div_in[l].ovf  = {16'd0, nmag[31:16]} >= dmag;
    end
  end

  // ------------------------------------------------------------------
  // Divider pipeline: stage 0 is the entry register, stage k has k bits
  // ------------------------------------------------------------------
  div_t  dv   [DIVSTEPS+1][LANES];
  side_t sd   [DIVSTEPS+1];
  logic  vld  [DIVSTEPS+1];
  div_t  dv_next [DIVSTEPS][LANES];

  always_comb begin
    logic [QW:0] t;
    logic        ge;
    for (int s = 0; s < DIVSTEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        t  = {dv[s][l].rem, dv[s][l].q[QW-1]};
        ge = t >= {1'b0, dv[s][l].dmag};
        dv_next[s][l]      = dv[s][l];
        dv_next[s][l].rem  = ge ? QW'(t - {1'b0, dv[s][l].dmag}) : t[QW-1:0];
        dv_next[s][l].q    = {dv[s][l].q[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIVSTEPS; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= ray_in.valid;
      for (int s = 0; s < DIVSTEPS; s++) begin
        vld[s+1] <= vld[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side_in;
      for (int l = 0; l < LANES; l++) begin
        dv[0][l] <= div_in[l];
      end
      for (int s = 0; s < DIVSTEPS; s++) begin
        sd[s+1] <= sd[s];
        for (int l = 0; l < LANES; l++) begin
          dv[s+1][l] <= dv_next[s][l];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Order stage: saturate quotients, order each slab pair. A parallel axis
  // contributes the open interval, which leaves tmin and tmax untouched.
  // ------------------------------------------------------------------
  logic signed [QW-1:0] sat [LANES];
  logic signed [QW-1:0] ta_next [AXES];
  logic signed [QW-1:0] tb_next [AXES];
  logic signed [QW-1:0] ta [AXES];
  logic signed [QW-1:0] tb [AXES];
  logic [AXES-1:0]      ord_pmiss;
  logic                 ord_vld;

  always_comb begin
    div_t d;
    for (int l = 0; l < LANES; l++) begin
      d = dv[DIVSTEPS][l];
      if (d.ovf) begin
        sat[l] = d.neg ? T_MIN_SAT : T_MAX_SAT;
      end else if (!d.neg) begin
        sat[l] = (d.q > 32'h7FFF_FFFF) ? T_MAX_SAT : d.q;
      end else begin
        sat[l] = (d.q > 32'h8000_0000) ? T_MIN_SAT : (~d.q + 32'd1);
      end
    end
    for (int a = 0; a < AXES; a++) begin
      if (sd[DIVSTEPS].par[a]) begin
        ta_next[a] = T_MIN_SAT;
        tb_next[a] = T_MAX_SAT;
      end else if (sat[a] > sat[a+AXES]) begin
        ta_next[a] = sat[a+AXES];
        tb_next[a] = sat[a];
      end else begin
        ta_next[a] = sat[a];
        tb_next[a] = sat[a+AXES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ord_vld <= 1'b0;
    end else if (adv) begin
      ord_vld <= vld[DIVSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta        <= ta_next;
      tb        <= tb_next;
      ord_pmiss <= sd[DIVSTEPS].pmiss & sd[DIVSTEPS].par;
    end
  end

  // ------------------------------------------------------------------
  // Reduce stage: tmin is the largest entry, tmax the smallest exit. The
  // running emptiness test of the slab loop equals tmin > tmax overall.
  // ------------------------------------------------------------------
  logic signed [QW-1:0] tmin_next, tmax_next, tmin, tmax;
  logic red_pmiss, red_vld;

  always_comb begin
    tmin_next = T_MIN_SAT;
    tmax_next = T_MAX_SAT;
    for (int a = 0; a < AXES; a++) begin
      if (ta[a] > tmin_next) tmin_next = ta[a];
      if (tb[a] < tmax_next) tmax_next = tb[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_vld <= 1'b0;
    end else if (adv) begin
      red_vld <= ord_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tmin      <= tmin_next;
      tmax      <= tmax_next;
      red_pmiss <= |ord_pmiss;
    end
  end

  // ------------------------------------------------------------------
  // Output register: miss, inside (distance 0), behind, or entry hit
  // ------------------------------------------------------------------
  logic             hit_next;
  logic [DISTW-1:0] dist_next;

  always_comb begin
    hit_next  = 1'b0;
    dist_next = '0;
    if (red_pmiss || (tmin > tmax)) begin
      hit_next = 1'b0;
    end else if (tmin < 0 && tmax > 0) begin
      hit_next = 1'b1;
    end else if (tmin < 0) begin
      hit_next = 1'b0;
    end else begin
      hit_next  = 1'b1;
      dist_next = tmin[DISTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= red_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit  <= hit_next;
      out_dist <= dist_next;
    end
  end

  assign hit_out.valid    = out_vld;
  assign hit_out.hit      = out_hit;
  assign hit_out.distance = out_dist;

endmodule

[src/rbsi_checker.sv]
// ----------------------------------------------------------------------------
// rbsi_checker: port-level checks for the ray/box slab intersect unit
// Watches the result and threshold channels and flags protocol or result slips.
// ----------------------------------------------------------------------------
module rbsi_checker
  import rbsi_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_hit,
  input logic [DISTW-1:0] out_distance,
  input logic             cfg_ready
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a miss always reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_distance == '0)
    else $error("miss with non-zero distance");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // threshold writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind ray_box_slab_intersect_unit rbsi_checker u_rbsi_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (hit_out.valid),
  .out_ready    (hit_out.ready),
  .out_hit      (hit_out.hit),
  .out_distance (hit_out.distance),
  .cfg_ready    (cfg.ready)
);
